// ===== rtl/oaids_pkg.sv =====
// shared types and constants for the ordered array insert/delete/search core
package oaids_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_SCAN = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [CMP_W-1:0]   pos;
    logic [CMP_W-1:0]   cnt;
    logic [DATA_W-1:0]  key;
    logic               search;
  } cell_ctrl_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  data;
  } chain_t;

endpackage

// ===== rtl/ordered_array_insert_delete_search_core.sv =====
// top level: packed ordered array in a row of cells with request sequencer
//
// A request beat is taken at a rising edge with start high and busy low:
// kind_i selects insert, delete, search or read, position_i gives the index
// and data_in_i the value to insert or look for. Every request gives one
// result beat, marked by done_o for exactly one cycle, carrying status_o,
// found_position_o, data_out_o and entry_count_o (count after the request).
// Insert, and any request rejected for a full array or a bad position,
// reports in the cycle after it is taken and busy stays low, so such
// requests can follow each other every cycle. Search, read and delete run
// the scan chain through all DEPTH cells toward cell 0, one cell per cycle,
// so the lowest matching cell wins; the result is registered from ST_DONE
// after ST_SCAN, with busy high from the cycle after the request until
// the result beat. A delete shifts the upper entries down as it reports.
// Reset clears the entry count and the sequencer; entry contents are not
// cleared. The receiver cannot stall: a result beat is taken in its cycle.
module ordered_array_insert_delete_search_core import oaids_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind_i,
  input  logic [7:0]               position_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [6:0]               found_position_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [7:0]               entry_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   scan_cnt_q, scan_cnt_d;
  kind_e              kind_q, kind_d;
  logic [7:0]         pos_q, pos_d;
  logic [DATA_W-1:0]  key_q, key_d;

  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [6:0]         fpos_q, fpos_d;
  logic [DATA_W-1:0]  dout_q, dout_d;
  logic [7:0]         ecnt_q, ecnt_d;

  cell_ctrl_t         ctrl;
  logic [CMP_W-1:0]   pos_w;
  logic [CMP_W-1:0]   cnt_w;
  logic [CMP_W-1:0]   new_cnt_w;
  logic [CMP_W-1:0]   res_idx_w;
  chain_t             res;

  logic [DATA_W-1:0]  entry  [DEPTH];
  chain_t             chain  [DEPTH];

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    chain_t            chain_in;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper    = '0;
      assign chain_in = '0;
    end else begin : g_mid_hi
      assign upper    = entry[i+1];
      assign chain_in = chain[i+1];
    end
    oaids_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(i)),
      .lower_i (lower),
      .upper_i (upper),
      .chain_i (chain_in),
      .entry_o (entry[i]),
      .chain_o (chain[i])
    );
  end

  assign res = chain[0];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_cnt_d = scan_cnt_q;
    kind_d     = kind_q;
    pos_d      = pos_q;
    key_d      = key_q;
    done_d     = 1'b0;
    status_d   = status_q;
    fpos_d     = fpos_q;
    dout_d     = dout_q;
    ecnt_d     = ecnt_q;
    pos_w      = CMP_W'(position_i);
    cnt_w      = CMP_W'(count_q);
    res_idx_w  = CMP_W'(res.idx);
    ctrl       = '{op: CELL_HOLD, pos: CMP_W'(pos_q), cnt: cnt_w, key: key_q,
                   search: (kind_q == KIND_SEARCH)};

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (kind_e'(kind_i)) inside
            KIND_INSERT: begin
              done_d = 1'b1;
              fpos_d = position_i[6:0];
              dout_d = '0;
              if (cnt_w >= DEPTH_W) begin
                status_d = STAT_FULL;
              end else if (pos_w > cnt_w) begin
                status_d = STAT_RANGE;
              end else begin
                status_d = STAT_OK;
                ctrl.op  = CELL_INS;
                ctrl.pos = pos_w;
                ctrl.key = data_in_i;
                count_d  = count_q + 1'b1;
              end
            end
            KIND_DELETE, KIND_READ: begin
              if (pos_w >= cnt_w) begin
                done_d   = 1'b1;
                status_d = STAT_RANGE;
                fpos_d   = position_i[6:0];
                dout_d   = '0;
              end else begin
                kind_d     = kind_e'(kind_i);
                pos_d      = position_i;
                key_d      = data_in_i;
                scan_cnt_d = '0;
                state_d    = ST_SCAN;
              end
            end
            default: begin
              kind_d     = kind_e'(kind_i);
              pos_d      = position_i;
              key_d      = data_in_i;
              scan_cnt_d = '0;
              state_d    = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctrl.op    = CELL_SCAN;
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == LAST_IDX) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d  = ST_IDLE;
        done_d   = 1'b1;
        status_d = STAT_OK;
        fpos_d   = pos_q[6:0];
        dout_d   = res.data;
        case (kind_q)
          KIND_SEARCH: begin
            if (res.hit) begin
              fpos_d = res_idx_w[6:0];
            end else begin
              status_d = STAT_MISS;
              dout_d   = '0;
            end
          end
          KIND_DELETE: begin
            ctrl.op = CELL_DEL;
            count_d = count_q - 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    new_cnt_w = CMP_W'(count_d);
    if (done_d) begin
      ecnt_d = new_cnt_w[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      scan_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_cnt_q <= scan_cnt_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    status_q <= status_d;
    fpos_q   <= fpos_d;
    dout_q   <= dout_d;
    ecnt_q   <= ecnt_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_position_o = fpos_q;
  assign data_out_o       = dout_q;
  assign entry_count_o    = ecnt_q;

  // count stays within the array
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= DEPTH_W)
    else $error("entry count above depth");

  // count moves by at most one per request
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
    else $error("entry count jumped");

  // scan end always yields a result beat
  a_scan_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> done_o)
    else $error("scan finished without result beat");

  // full rejection reports a full array
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> (entry_count_o == DEPTH_W[7:0]))
    else $error("full status with wrong count");

endmodule

// ===== rtl/oaids_cell.sv =====
// one array cell: holds an entry, shifts with its neighbors, forwards the scan chain
module oaids_cell import oaids_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [DATA_W-1:0] lower_i,
  input  logic [DATA_W-1:0] upper_i,
  input  chain_t            chain_i,
  output logic [DATA_W-1:0] entry_o,
  output chain_t            chain_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  chain_t            chain_q, chain_d;
  logic [CMP_W-1:0]  idx_w;
  logic              live;
  logic              hit;

  always_comb begin
    idx_w = CMP_W'(idx_i);
    live  = idx_w < ctrl_i.cnt;
    hit   = live && (ctrl_i.search ? (entry_q == ctrl_i.key) : (idx_w == ctrl_i.pos));
    entry_d = entry_q;
    chain_d = chain_q;
    unique case (ctrl_i.op)
      CELL_INS: begin
        if (idx_w > ctrl_i.pos) begin
          entry_d = lower_i;
        end else if (idx_w == ctrl_i.pos) begin
          entry_d = ctrl_i.key;
        end
      end
      CELL_DEL: begin
        if (idx_w >= ctrl_i.pos) begin
          entry_d = upper_i;
        end
      end
      CELL_SCAN: begin
        if (hit) begin
          chain_d = '{hit: 1'b1, idx: idx_i, data: entry_q};
        end else begin
          chain_d = chain_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    chain_q <= chain_d;
  end

  assign entry_o = entry_q;
  assign chain_o = chain_q;

endmodule
